FILE: src/cc20_pkg.sv
// shared types, constants and functions for the chacha20 stream cipher
// no dependencies; imported by every module of the block
package cc20_pkg;

  // chacha20 state constants, "expand 32-byte k"
  localparam logic [31:0] CC_C0 = 32'h61707865;
  localparam logic [31:0] CC_C1 = 32'h3320646e;
  localparam logic [31:0] CC_C2 = 32'h79622d32;
  localparam logic [31:0] CC_C3 = 32'h6b206574;

  // 20 rounds, alternating column and diagonal
  localparam int NUM_ROUNDS = 20;
  localparam int RND_W      = 5;
  localparam int NUM_WORDS  = 16;
  localparam int POS_W      = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_01    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_23    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_45    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_67    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_01  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CTR_START = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FEED,
    ST_EMIT
  } cc20_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;       // input item taken this cycle
    logic load_init;    // start a new keystream block
    logic do_round;     // run one column or diagonal round
    logic diag;         // 1: diagonal round
    logic feed;         // feed-forward add into the keystream store
    logic emit_direct;  // load result from the accepted item
    logic emit_held;    // load result from the held word-zero item
  } cc20_cmd_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } cc20_qr_t;

  function automatic logic [31:0] cc20_rol16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  function automatic logic [31:0] cc20_rol12(input logic [31:0] v);
    return {v[19:0], v[31:20]};
  endfunction

  function automatic logic [31:0] cc20_rol8(input logic [31:0] v);
    return {v[23:0], v[31:24]};
  endfunction

  function automatic logic [31:0] cc20_rol7(input logic [31:0] v);
    return {v[24:0], v[31:25]};
  endfunction

  // one full quarter round
  function automatic cc20_qr_t cc20_qround(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] a1, b1, c1, d1, a2, b2, c2, d2;
    cc20_qr_t    r;
    a1 = a + b;
    d1 = cc20_rol16(d ^ a1);
    c1 = c + d1;
    b1 = cc20_rol12(b ^ c1);
    a2 = a1 + b1;
    d2 = cc20_rol8(d1 ^ a2);
    c2 = c1 + d2;
    b2 = cc20_rol7(b1 ^ c2);
    r.a = a2;
    r.b = b2;
    r.c = c2;
    r.d = d2;
    return r;
  endfunction

  function automatic logic [31:0] cc20_bswap(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

FILE: src/cc20_in_if.sv
// input channel: payload words with a last-word flag
// no dependencies
interface cc20_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic        last_word;

  modport source (output valid, output data_word, output last_word, input ready);
  modport sink   (input valid, input data_word, input last_word, output ready);
endinterface

FILE: src/cc20_out_if.sv
// result channel: cipher words with a last-word flag
// no dependencies
interface cc20_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cipher_word;
  logic        last_out;

  modport source (output valid, output cipher_word, output last_out, input ready);
  modport sink   (input valid, input cipher_word, input last_out, output ready);
endinterface

FILE: src/chacha20_stream_cipher.sv
// chacha20 stream cipher, top level: controller plus datapath
// depends on cc20_pkg, cc20_in_if, cc20_out_if, cc20_ctrl, cc20_datapath
//
// usage: payload words enter on in_chan (valid/ready), first byte in bits
// 31:24, with last_word on the final word of a packet. each item gives one
// item on out_chan: the word xor the byte-swapped keystream word.
// configuration: cfg_we, cfg_index and cfg_data write key, nonce and
// counter_start registers; the user must write them only while the block
// is idle, the block itself does not enforce this. a word at a nonzero
// block position is written to the output register as it is taken. word
// zero of a block waits for the block build: 20 rounds of four quarter-round
// units, one round per cycle, then a feed-forward step and an output step
// that waits for a free output register. no new item is taken during a
// block build; a packet's last word resets position and counter.
// reset: position zero, block counter 1, all key and nonce registers zero.
// stall: the output register holds its item while out_chan.ready is low;
// a new item is taken when that register is empty or being emptied.
module chacha20_stream_cipher import cc20_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  cc20_in_if.sink               in_chan,
  cc20_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cc20_cmd_t cmd;
  logic      pos_zero;

  cc20_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .pos_zero  (pos_zero),
    .cmd       (cmd)
  );

  cc20_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .data_word   (in_chan.data_word),
    .last_word   (in_chan.last_word),
    .cmd         (cmd),
    .pos_zero    (pos_zero),
    .cipher_word (out_chan.cipher_word),
    .last_out    (out_chan.last_out)
  );

  // no input item is taken while rounds are running
  a_no_accept_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_round |-> !in_chan.ready)
    else $error("input accepted during block build");

  // word zero of a block starts the round sequence on the next cycle
  a_build_follows_word0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && pos_zero) |=> cmd.do_round)
    else $error("block build did not start after word zero");

  // a direct result only comes from an accepted item past word zero
  a_direct_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_direct |-> (in_chan.valid && in_chan.ready && !pos_zero))
    else $error("direct result without a matching input item");

  // a result is loaded only into an empty or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_direct || cmd.emit_held) |-> (!out_chan.valid || out_chan.ready))
    else $error("output register overwritten while stalled");

endmodule

FILE: src/cc20_ctrl.sv
// controller: sequences block build, round count and output handshake
// depends on cc20_pkg
module cc20_ctrl import cc20_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  logic      pos_zero,
  output cc20_cmd_t cmd
);

  localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(NUM_ROUNDS - 1);

  cc20_state_t      state_r, state_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  // output register can take a new item
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && out_free && pos_zero) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd_r == LAST_ROUND) state_nxt = ST_FEED;
      end
      ST_FEED: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready        = out_free;
        cmd.accept      = in_valid && out_free;
        cmd.load_init   = in_valid && out_free && pos_zero;
        cmd.emit_direct = in_valid && out_free && !pos_zero;
      end
      ST_ROUND: begin
        cmd.do_round = 1'b1;
        cmd.diag     = rnd_r[0];
      end
      ST_FEED: begin
        cmd.feed = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit_held = out_free;
      end
      default: ;
    endcase
  end

  // round counter and output valid
  always_comb begin
    rnd_nxt = cmd.do_round ? rnd_r + RND_W'(1) : '0;
    if (cmd.emit_direct || cmd.emit_held) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/cc20_datapath.sv
// datapath: config registers, working state with four quarter-round units,
// keystream store, word position, block counter and output register
// depends on cc20_pkg
module cc20_datapath import cc20_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [31:0]           data_word,
  input  logic                  last_word,
  input  cc20_cmd_t             cmd,
  output logic                  pos_zero,
  output logic [31:0]           cipher_word,
  output logic                  last_out
);

  logic [63:0]      key01_r, key23_r, key45_r, key67_r, nonce01_r;
  logic [31:0]      nonce2_r, ctr_start_r;
  logic [31:0]      ctr_r, ctr_snap_r;
  logic [POS_W-1:0] pos_r;
  logic [31:0]      w_r   [NUM_WORDS];
  logic [31:0]      w_nxt [NUM_WORDS];
  logic [31:0]      ks_r  [NUM_WORDS];
  logic [31:0]      init_w [NUM_WORDS];
  logic [31:0]      hold_data_r;
  logic             hold_last_r;
  logic [31:0]      cipher_r;
  logic             last_r;

  assign pos_zero    = (pos_r == '0);
  assign cipher_word = cipher_r;
  assign last_out    = last_r;

  // input matrix of the block being built
  always_comb begin
    init_w[0]  = CC_C0;
    init_w[1]  = CC_C1;
    init_w[2]  = CC_C2;
    init_w[3]  = CC_C3;
    init_w[4]  = key01_r[31:0];
    init_w[5]  = key01_r[63:32];
    init_w[6]  = key23_r[31:0];
    init_w[7]  = key23_r[63:32];
    init_w[8]  = key45_r[31:0];
    init_w[9]  = key45_r[63:32];
    init_w[10] = key67_r[31:0];
    init_w[11] = key67_r[63:32];
    init_w[12] = ctr_snap_r;
    init_w[13] = nonce01_r[31:0];
    init_w[14] = nonce01_r[63:32];
    init_w[15] = nonce2_r;
  end

  // one column or diagonal round: four independent quarter rounds
  always_comb begin
    logic [1:0]       q, ob, oc, od;
    logic [POS_W-1:0] ia, ib, ic, id;
    cc20_qr_t         qr;
    for (int k = 0; k < NUM_WORDS; k++) w_nxt[k] = w_r[k];
    for (int i = 0; i < 4; i++) begin
      q  = 2'(i);
      ob = q + {1'b0, cmd.diag};
      oc = q + {cmd.diag, 1'b0};
      od = q + {cmd.diag, cmd.diag};
      ia = {2'd0, q};
      ib = {2'd1, ob};
      ic = {2'd2, oc};
      id = {2'd3, od};
      qr = cc20_qround(w_r[ia], w_r[ib], w_r[ic], w_r[id]);
      w_nxt[ia] = qr.a;
      w_nxt[ib] = qr.b;
      w_nxt[ic] = qr.c;
      w_nxt[id] = qr.d;
    end
  end

  // configuration registers, position and block counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r     <= '0;
      key23_r     <= '0;
      key45_r     <= '0;
      key67_r     <= '0;
      nonce01_r   <= '0;
      nonce2_r    <= '0;
      ctr_start_r <= 32'd1;
      ctr_r       <= 32'd1;
      pos_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_01:   key01_r   <= cfg_data;
        REG_KEY_23:   key23_r   <= cfg_data;
        REG_KEY_45:   key45_r   <= cfg_data;
        REG_KEY_67:   key67_r   <= cfg_data;
        REG_NONCE_01: nonce01_r <= cfg_data;
        REG_NONCE_2:  nonce2_r  <= cfg_data[31:0];
        REG_CTR_START: begin
          ctr_start_r <= cfg_data[31:0];
          ctr_r       <= cfg_data[31:0];
        end
        default: ;
      endcase
    end else if (cmd.accept) begin
      if (last_word) begin
        pos_r <= '0;
        ctr_r <= ctr_start_r;
      end else begin
        pos_r <= pos_r + POS_W'(1);
        if (pos_zero) ctr_r <= ctr_r + 32'd1;
      end
    end
  end

  // working state, keystream store and held word-zero item
  always_ff @(posedge clk) begin
    if (cmd.load_init) begin
      for (int k = 0; k < NUM_WORDS; k++) w_r[k] <= init_w[k];
      w_r[12]     <= ctr_r;
      ctr_snap_r  <= ctr_r;
      hold_data_r <= data_word;
      hold_last_r <= last_word;
    end else if (cmd.do_round) begin
      for (int k = 0; k < NUM_WORDS; k++) w_r[k] <= w_nxt[k];
    end
    if (cmd.feed) begin
      for (int k = 0; k < NUM_WORDS; k++) ks_r[k] <= w_r[k] + init_w[k];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit_direct) begin
      cipher_r <= data_word ^ cc20_bswap(ks_r[pos_r]);
      last_r   <= last_word;
    end else if (cmd.emit_held) begin
      cipher_r <= hold_data_r ^ cc20_bswap(ks_r[0]);
      last_r   <= hold_last_r;
    end
  end

endmodule
